// File: src/oss_pkg.sv
// shared types and constants for the ordered selection sampler
`timescale 1ns / 1ps

package oss_pkg;

    localparam int WORD_BITS      = 32;
    localparam int CNT_BITS       = $clog2(WORD_BITS);
    localparam int SEL_BITS       = 24;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int DEF_INDEX_BITS = 24;
    localparam int TOTAL_RESET    = 16;

    typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_TOTAL_COUNT = cfg_addr_t'(0);
    localparam cfg_addr_t REG_PICK_COUNT  = cfg_addr_t'(1);

    typedef struct packed {
        logic                 begin_run;
        logic [WORD_BITS-1:0] random_word;
    } in_word_t;

    typedef struct packed {
        logic [SEL_BITS-1:0] selected_index;
        logic                last_pick;
    } out_word_t;

endpackage

// File: src/ordered_selection_sampler.sv
// ordered selection sampler: picks m of n indices in ascending order, one position per word
// result: a deciding word's result follows 32 remainder steps in the shared restoring
//   subtractor and a decision; run-ending or idle words give none
// input: no new word is taken while a word is being decided, and a waiting result blocks the
//   decision; the next word is taken while a result still waits; ignored words: one per cycle
// reset: rst_n async active low; total_count = 16, pick_count = 0, no run, output empty
`timescale 1ns / 1ps

module ordered_selection_sampler
    import oss_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_addr_t                cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,

    // input words
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_word_t                 in_data,

    // result words
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_word_t                out_data
);

    typedef logic [INDEX_BITS-1:0] idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    state_t              state_reg;
    logic                running_reg;
    idx_t                total_reg;
    idx_t                pick_reg;
    idx_t                position_reg;
    idx_t                picks_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                out_valid_reg;
    out_word_t           out_data_reg;

    // remainder datapath, no reset needed
    logic [WORD_BITS-1:0] word_reg;
    idx_t                 divisor_reg;
    idx_t                 rem_reg;
    idx_t                 rem_next;

    // accept-side decode
    idx_t pick_sat;
    idx_t pos_eff;
    idx_t picks_eff;
    logic run_eff;
    logic stop_now;
    idx_t left;

    // decision-side decode
    logic hit;
    idx_t pos_inc;
    idx_t picks_dec;
    logic run_end;
    logic out_busy;
    logic out_load;

    // shared restoring step
    logic [INDEX_BITS:0]   rem_shift;
    logic [INDEX_BITS+1:0] rem_diff;

    logic in_fire;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_busy  = out_valid_reg && !out_ready;
    assign out_load  = (state_reg == ST_FINISH) && hit && !out_busy;

    // begin_run reloads counters; pick count saturates to the live total
    always_comb
    begin
        pick_sat  = (pick_reg > total_reg) ? total_reg : pick_reg;
        pos_eff   = in_data.begin_run ? '0 : position_reg;
        picks_eff = in_data.begin_run ? pick_sat : picks_reg;
        run_eff   = in_data.begin_run || running_reg;
        stop_now  = (picks_eff == '0) || (pos_eff >= total_reg);
        left      = total_reg - pos_eff;
    end

    // one quotient bit per cycle: shift in the next word bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, word_reg[WORD_BITS-1]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, divisor_reg};
        if (rem_diff[INDEX_BITS+1])
        begin
            rem_next = rem_shift[INDEX_BITS-1:0];
        end
        else
        begin
            rem_next = rem_diff[INDEX_BITS-1:0];
        end
    end

    // pick when remainder is below the picks still needed
    always_comb
    begin
        hit       = (rem_reg < picks_reg);
        pos_inc   = position_reg + idx_t'(1);
        picks_dec = hit ? (picks_reg - idx_t'(1)) : picks_reg;
        run_end   = (picks_dec == '0) || (pos_inc >= total_reg) || (pos_inc == '0);
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rem_reg     <= '0;
                word_reg    <= in_data.random_word;
                divisor_reg <= left;
            end
            ST_DIV:
            begin
                rem_reg  <= rem_next;
                word_reg <= {word_reg[WORD_BITS-2:0], 1'b0};
            end
            ST_FINISH:
            begin
                rem_reg <= rem_reg;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            total_reg     <= idx_t'(TOTAL_RESET);
            pick_reg      <= '0;
            position_reg  <= '0;
            picks_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // config writes land only while idle; other indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_addr == REG_TOTAL_COUNT)
                begin
                    total_reg <= idx_t'(cfg_data);
                end
                else if (cfg_addr == REG_PICK_COUNT)
                begin
                    pick_reg <= idx_t'(cfg_data);
                end
            end

            // a new pick refills the output register in the cycle the old one leaves
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && run_eff)
                    begin
                        position_reg <= pos_eff;
                        picks_reg    <= picks_eff;
                        if (stop_now)
                        begin
                            running_reg <= 1'b0;
                        end
                        else
                        begin
                            running_reg <= 1'b1;
                            cnt_reg     <= '0;
                            state_reg   <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // hold the decision until the output register is free
                    if (!(hit && out_busy))
                    begin
                        if (hit)
                        begin
                            out_data_reg.selected_index <= SEL_BITS'(position_reg);
                            out_data_reg.last_pick      <= (picks_dec == '0);
                        end
                        picks_reg    <= picks_dec;
                        position_reg <= pos_inc;
                        if (run_end)
                        begin
                            running_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // partial remainder always stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < divisor_reg))
        else $error("remainder not below divisor");

    // the remainder loop runs its full length before a decision
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != CNT_LAST) |=> (state_reg == ST_DIV))
        else $error("remainder loop cut short");

    // a live run always has picks outstanding
    a_run_picks: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (picks_reg != '0))
        else $error("run active with no picks left");

    // a freshly loaded final pick ends the run
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && out_data_reg.last_pick) |-> !running_reg)
        else $error("run still active after last pick");
`endif

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the ordered selection sampler
`timescale 1ns / 1ps

module tb_top;
    import oss_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    localparam int IDX_W          = DEF_INDEX_BITS;
    // settle time that covers a word still in the remainder loop
    localparam int SETTLE_CYCLES  = 40;
    // watchdog limit, set with a wide margin
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int RANDOM_ITEMS   = 1725;
    // cap on words fed after a run's first word, keeps runs over huge totals short
    localparam int RUN_CAP        = 60;
    // receiver hold-off: HOLD_EVERY sets how often the output side stops, HOLD_LEN how long
    localparam int HOLD_EVERY     = 15000;
    localparam int HOLD_LEN       = 400;

    // register indexes with no register behind them, writes must be dropped
    localparam cfg_addr_t REG_SPARE_A = cfg_addr_t'(2);
    localparam cfg_addr_t REG_SPARE_B = cfg_addr_t'(3);

    // directed script row types
    typedef enum logic [1:0] {STEP_WORD, STEP_CFG, STEP_DRAIN} step_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PICK} step_chk_t;

    typedef struct packed {
        step_kind_t               kind;
        cfg_addr_t                addr;
        logic [CFG_DATA_BITS-1:0] data;
        logic                     begin_run;
        logic [WORD_BITS-1:0]     rword;
        step_chk_t                chk;
        logic [SEL_BITS-1:0]      idx;
        logic                     last;
    } step_t;

    function automatic step_t wrow(logic b, logic [WORD_BITS-1:0] wd, step_chk_t chk,
                                   logic [SEL_BITS-1:0] idx, logic last);
        step_t r;
        r = '0;
        r.kind      = STEP_WORD;
        r.begin_run = b;
        r.rword     = wd;
        r.chk       = chk;
        r.idx       = idx;
        r.last      = last;
        return r;
    endfunction

    function automatic step_t crow(cfg_addr_t addr, logic [CFG_DATA_BITS-1:0] data);
        step_t r;
        r = '0;
        r.kind = STEP_CFG;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    function automatic step_t drow();
        step_t r;
        r = '0;
        r.kind = STEP_DRAIN;
        return r;
    endfunction

    localparam int SCRIPT_LEN = 41;

    // directed part: typed expectations where they are obvious, the rest goes to the predictor
    localparam step_t SCRIPT [SCRIPT_LEN] = '{
        // after reset: no run, and pick count 0 means a begin ends at once
        wrow(1'b0, 32'h0000_0000, CHK_NONE, 24'd0, 1'b0),
        wrow(1'b1, 32'hFFFF_FFFF, CHK_NONE, 24'd0, 1'b0),
        drow(),
        // single candidate, pick count saturates to total; spare indexes ignored
        crow(REG_TOTAL_COUNT, 24'd1),
        crow(REG_PICK_COUNT, 24'hFF_FFFF),
        crow(REG_SPARE_A, 24'h00_0000),
        crow(REG_SPARE_B, 24'hFF_FFFF),
        wrow(1'b1, 32'hFFFF_FFFF, CHK_PICK, 24'd0, 1'b1),
        wrow(1'b0, 32'h0000_0000, CHK_NONE, 24'd0, 1'b0),
        drow(),
        // largest total, one pick
        crow(REG_TOTAL_COUNT, 24'hFF_FFFF),
        crow(REG_PICK_COUNT, 24'd1),
        wrow(1'b1, 32'hFFFF_FFFF, CHK_MODEL, 24'd0, 1'b0),
        wrow(1'b0, 32'h0000_0000, CHK_PICK, 24'd1, 1'b1),
        drow(),
        // pick everything: every position is chosen
        crow(REG_PICK_COUNT, 24'hFF_FFFF),
        wrow(1'b1, 32'hAAAA_AAAA, CHK_PICK, 24'd0, 1'b0),
        wrow(1'b0, 32'h5555_5555, CHK_PICK, 24'd1, 1'b0),
        drow(),
        // total lowered to the current position mid-run: run stops silently
        crow(REG_TOTAL_COUNT, 24'd2),
        wrow(1'b0, 32'h0000_0000, CHK_NONE, 24'd0, 1'b0),
        drow(),
        crow(REG_TOTAL_COUNT, 24'd8),
        crow(REG_PICK_COUNT, 24'd6),
        wrow(1'b1, 32'h0000_0000, CHK_PICK, 24'd0, 1'b0),
        wrow(1'b0, 32'h0000_0000, CHK_PICK, 24'd1, 1'b0),
        drow(),
        // total lowered below picks still needed: rest is picked, never flagged last
        crow(REG_TOTAL_COUNT, 24'd5),
        wrow(1'b0, 32'hFFFF_FFFF, CHK_PICK, 24'd2, 1'b0),
        wrow(1'b0, 32'h1234_5678, CHK_PICK, 24'd3, 1'b0),
        wrow(1'b0, 32'hFFFF_FFFF, CHK_PICK, 24'd4, 1'b0),
        wrow(1'b0, 32'h0000_0000, CHK_NONE, 24'd0, 1'b0),
        drow(),
        // zero total: nothing to pick
        crow(REG_TOTAL_COUNT, 24'd0),
        wrow(1'b1, 32'h0000_0001, CHK_NONE, 24'd0, 1'b0),
        drow(),
        crow(REG_TOTAL_COUNT, 24'd10),
        crow(REG_PICK_COUNT, 24'd3),
        // restart in the middle of a run
        wrow(1'b1, 32'h0000_0007, CHK_MODEL, 24'd0, 1'b0),
        wrow(1'b1, 32'h8000_0001, CHK_MODEL, 24'd0, 1'b0),
        wrow(1'b0, 32'h7FFF_FFFE, CHK_MODEL, 24'd0, 1'b0)
    };

    // dut ports; the inputs are driven to known values from time zero
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    cfg_addr_t                cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    in_word_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_word_t                out_data;

    ordered_selection_sampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // predictor state: configuration copy plus the sampler's own counters
    logic [IDX_W-1:0] tot_reg   = IDX_W'(TOTAL_RESET);
    logic [IDX_W-1:0] pick_reg  = '0;
    logic [IDX_W-1:0] cur_pos   = '0;
    logic [IDX_W-1:0] need_left = '0;
    logic             in_run    = 1'b0;

    out_word_t pending_picks [$];
    int        fault_count = 0;
    int        live_items  = 0;
    int        burst_left  = 0;

    // at most one position decision per accepted word; live means the word was not simply ignored
    task automatic decide_position(input in_word_t w, output bit live, output bit hit,
                                   output out_word_t pick);
        logic [IDX_W-1:0]     n;
        logic [IDX_W-1:0]     span;
        logic [WORD_BITS-1:0] rem;
        n    = tot_reg;
        live = w.begin_run || in_run;
        hit  = 1'b0;
        pick = '0;
        if (w.begin_run)
        begin
            cur_pos   = '0;
            need_left = (pick_reg > n) ? n : pick_reg;
            in_run    = 1'b1;
        end
        if (!in_run)
            return;
        // run already over: nothing left to pick, or total moved below position
        if (need_left == '0 || cur_pos >= n)
        begin
            in_run = 1'b0;
            return;
        end
        span = n - cur_pos;
        rem  = w.random_word % WORD_BITS'(span);
        if (rem < WORD_BITS'(need_left))
        begin
            need_left           = need_left - 1'b1;
            hit                 = 1'b1;
            pick.selected_index = SEL_BITS'(cur_pos);
            pick.last_pick      = (need_left == '0);
        end
        cur_pos = cur_pos + 1'b1;
        if (need_left == '0 || cur_pos >= n || cur_pos == '0)
            in_run = 1'b0;
    endtask

    // present one word in bursts with random gaps, wait for the handshake, then predict
    task automatic push_word(input logic b, input logic [WORD_BITS-1:0] wd, output bit live,
                             output bit hit, output out_word_t pick);
        in_word_t w;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        w.begin_run   = b;
        w.random_word = wd;
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        decide_position(w, live, hit, pick);
    endtask

    // random part: word through the predictor, expectation queued
    task automatic feed(input logic b, input logic [WORD_BITS-1:0] wd);
        bit        live;
        bit        hit;
        out_word_t pick;
        push_word(b, wd, live, hit, pick);
        if (hit)
            pending_picks.push_back(pick);
        if (live)
            live_items++;
    endtask

    // register write; valid stays up so back-to-back writes need no gap
    task automatic write_reg(input cfg_addr_t addr, input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (addr == REG_TOTAL_COUNT)
            tot_reg = IDX_W'(data);
        else if (addr == REG_PICK_COUNT)
            pick_reg = IDX_W'(data);
    endtask

    // let every expected result come out, then cover a word still in the remainder loop
    task automatic settle();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random words lean toward full range, with some small ones to hit low remainders
    function automatic logic [WORD_BITS-1:0] draw_word();
        if ($urandom_range(0, 3) == 0)
            return WORD_BITS'($urandom_range(0, 63));
        return $urandom;
    endfunction

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

    // receiver: stretches of always-ready, random stalls and short blocks,
    // plus a periodic long hold-off so the block fills up and stalls its input
    initial
    begin
        int  cyc;
        int  hold_left;
        int  mode;
        int  mode_left;
        logic rdy;
        cyc       = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (cyc % HOLD_EVERY == 0)
            begin
                hold_left = HOLD_LEN;
                rdy       = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 9);
                    mode_left = (mode >= 8) ? $urandom_range(1, 15) : $urandom_range(20, 200);
                end
                mode_left--;
                if (mode < 4)
                    rdy = 1'b1;
                else if (mode < 8)
                    rdy = ($urandom_range(0, 1) == 1);
                else
                    rdy = 1'b0;
            end
            out_ready <= rdy;
        end
    end

    // result checker: oldest expectation against each accepted result word
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("selected_index: expected no word, got %0d (last_pick %0b)",
                       out_data.selected_index, out_data.last_pick);
                fault_count++;
            end
            else
            begin
                exp_w = pending_picks.pop_front();
                if (out_data.selected_index !== exp_w.selected_index)
                begin
                    $error("selected_index: expected %0d, got %0d",
                           exp_w.selected_index, out_data.selected_index);
                    fault_count++;
                end
                if (out_data.last_pick !== exp_w.last_pick)
                begin
                    $error("last_pick: expected %0b, got %0b",
                           exp_w.last_pick, out_data.last_pick);
                    fault_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        bit        live;
        bit        hit;
        out_word_t pick;
        out_word_t typed;
        int        n_val;
        int        m_val;
        int        run_len;
        int        lo;
        bit        live_done;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed script
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            case (SCRIPT[i].kind)
                STEP_CFG:
                    write_reg(SCRIPT[i].addr, SCRIPT[i].data);
                STEP_DRAIN:
                begin
                    cfg_valid <= 1'b0;
                    settle();
                end
                default:
                begin
                    cfg_valid <= 1'b0;
                    push_word(SCRIPT[i].begin_run, SCRIPT[i].rword, live, hit, pick);
                    if (live)
                        live_items++;
                    if (SCRIPT[i].chk == CHK_MODEL)
                    begin
                        if (hit)
                            pending_picks.push_back(pick);
                    end
                    else if (SCRIPT[i].chk == CHK_PICK)
                    begin
                        typed.selected_index = SCRIPT[i].idx;
                        typed.last_pick      = SCRIPT[i].last;
                        pending_picks.push_back(typed);
                    end
                end
            endcase
        end

        // random runs: fresh configuration, then a well-formed run with some noise
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    n_val = $urandom_range(1, 40);
                    m_val = $urandom_range(0, n_val + 3);
                end
                6:
                begin
                    n_val = 24'hFF_FFFF;
                    m_val = $urandom_range(0, 1) ? 24'hFF_FFFF : $urandom_range(0, 8);
                end
                7:
                begin
                    n_val = $urandom_range(1, 8);
                    m_val = 24'hFF_FFFF;
                end
                8:
                begin
                    n_val = $urandom_range(41, 5000);
                    m_val = $urandom_range(0, 60);
                end
                default:
                begin
                    // full-width values so every data bit toggles
                    n_val = $urandom_range(1, 24'hFF_FFFF);
                    m_val = $urandom_range(0, 24'hFF_FFFF);
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_TOTAL_COUNT, CFG_DATA_BITS'(n_val));
                write_reg(REG_PICK_COUNT, CFG_DATA_BITS'(m_val));
            end
            else
            begin
                write_reg(REG_PICK_COUNT, CFG_DATA_BITS'(m_val));
                write_reg(REG_TOTAL_COUNT, CFG_DATA_BITS'(n_val));
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_BITS'($urandom));
            cfg_valid <= 1'b0;

            feed(1'b1, draw_word());
            run_len   = 0;
            live_done = 1'b0;
            while (in_run && run_len < RUN_CAP)
            begin
                if ($urandom_range(0, 29) == 0)
                    feed(1'b1, draw_word());
                else if (!live_done && $urandom_range(0, 19) == 0)
                begin
                    // move the total near the current position while the run is live
                    live_done = 1'b1;
                    settle();
                    lo = (int'(cur_pos) > 3) ? int'(cur_pos) - 3 : 0;
                    write_reg(REG_TOTAL_COUNT,
                              CFG_DATA_BITS'($urandom_range(lo, int'(cur_pos) + 3)));
                    cfg_valid <= 1'b0;
                end
                else
                    feed(1'b0, draw_word());
                run_len++;
            end
            // extra words without begin; the block ignores them once the run has ended
            repeat ($urandom_range(0, 2)) feed(1'b0, draw_word());
        end

        settle();
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
